[hdl/assert_macros.svh]
// Assertion macros for the checker file of this project.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cfc_pkg.sv]
// Package for the continued-fraction tangle classifier.
// Holds field widths, parity codes, controller states and the control structs.
// No dependencies.
package cfc_pkg;

    localparam int unsigned TWIST_W   = 16;
    localparam int unsigned FIELD_W   = 16;
    localparam int unsigned PARITY_W  = 2;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 72;
    localparam int unsigned M_TUSER_W = 2;
    localparam int unsigned M_PAD_W   = M_TDATA_W - 4 * FIELD_W - PARITY_W;

    // Parity classes of the final fraction.
    localparam logic [PARITY_W-1:0] PAR_ZERO     = 2'd0;
    localparam logic [PARITY_W-1:0] PAR_ONE      = 2'd1;
    localparam logic [PARITY_W-1:0] PAR_INFINITY = 2'd2;
    localparam logic [PARITY_W-1:0] PAR_FAIL     = 2'd3;

    // Remainder operand order.
    localparam logic SEL_P_MOD_Q = 1'b0;
    localparam logic SEL_Q_MOD_P = 1'b1;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_START_P,
        ST_REM_P,
        ST_START_Q,
        ST_REM_Q,
        ST_EMIT
    } cfc_state_t;

    typedef struct packed {
        logic step;       // advance the recurrence with the accepted word
        logic finish;     // accepted word is the last one: latch and restart
        logic div_start;  // launch the remainder unit
        logic div_sel;    // operand order for the remainder unit
        logic save_rem;   // keep p mod q
        logic out_load;   // load the output register
    } cfc_cmd_t;

    typedef struct packed {
        logic div_done;
    } cfc_sts_t;

    typedef struct packed {
        logic [PARITY_W-1:0] parity_code;
        logic                den_class_bad;
        logic                num_class_bad;
        logic [FIELD_W-1:0]  den_class;
        logic [FIELD_W-1:0]  num_class;
        logic [FIELD_W-1:0]  denominator;
        logic [FIELD_W-1:0]  numerator;
    } cfc_result_t;

endpackage

[hdl/cfc_rem.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on nothing; used by cfc_datapath.
module cfc_rem #(
    parameter int unsigned W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] rem
);

    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        done_next = (cnt_reg == CNT_W'(1));
        if (start)
        begin
            cnt_next = CNT_W'(W);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            // Keep the difference when the trial value reached the divisor.
            rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[hdl/cfc_datapath.sv]
// Datapath: convergent recurrence, final operands, remainder unit, output register.
// Depends on cfc_pkg and cfc_rem.
module cfc_datapath
    import cfc_pkg::*;
#(
    parameter int unsigned W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfc_cmd_t           cmd,
    output cfc_sts_t           sts,
    input  logic [TWIST_W-1:0] twist,
    output cfc_result_t        result
);

    logic [W-1:0] num_cur_reg, num_cur_next;
    logic [W-1:0] num_prev_reg, num_prev_next;
    logic [W-1:0] den_cur_reg, den_cur_next;
    logic [W-1:0] den_prev_reg, den_prev_next;
    logic [W-1:0] fin_p_reg, fin_p_next;
    logic [W-1:0] fin_q_reg, fin_q_next;
    logic [W-1:0] rem_p_reg, rem_p_next;
    cfc_result_t  res_reg, res_next;
    logic [W-1:0] a_w;
    logic [W-1:0] p_new;
    logic [W-1:0] q_new;
    logic [W-1:0] div_dvd;
    logic [W-1:0] div_dvs;
    logic         div_done;
    logic [W-1:0] div_rem;
    logic         q_zero;
    logic         p_zero;

    // Products wrap at the datapath width.
    always_comb
    begin
        a_w   = W'(twist);
        p_new = a_w * num_cur_reg + num_prev_reg;
        q_new = a_w * den_cur_reg + den_prev_reg;
    end

    always_comb
    begin
        num_cur_next  = num_cur_reg;
        num_prev_next = num_prev_reg;
        den_cur_next  = den_cur_reg;
        den_prev_next = den_prev_reg;
        fin_p_next    = fin_p_reg;
        fin_q_next    = fin_q_reg;
        if (cmd.finish)
        begin
            num_cur_next  = W'(1);
            num_prev_next = '0;
            den_cur_next  = '0;
            den_prev_next = W'(1);
            fin_p_next    = p_new;
            fin_q_next    = q_new;
        end
        else if (cmd.step)
        begin
            num_cur_next  = p_new;
            num_prev_next = num_cur_reg;
            den_cur_next  = q_new;
            den_prev_next = den_cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cur_reg  <= W'(1);
            num_prev_reg <= '0;
            den_cur_reg  <= '0;
            den_prev_reg <= W'(1);
        end
        else
        begin
            num_cur_reg  <= num_cur_next;
            num_prev_reg <= num_prev_next;
            den_cur_reg  <= den_cur_next;
            den_prev_reg <= den_prev_next;
        end
    end

    assign div_dvd = (cmd.div_sel == SEL_Q_MOD_P) ? fin_q_reg : fin_p_reg;
    assign div_dvs = (cmd.div_sel == SEL_Q_MOD_P) ? fin_p_reg : fin_q_reg;

    cfc_rem #(
        .W (W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign sts.div_done = div_done;
    assign rem_p_next   = cmd.save_rem ? div_rem : rem_p_reg;

    always_comb
    begin
        q_zero   = (fin_q_reg == '0);
        p_zero   = (fin_p_reg == '0);
        res_next = res_reg;
        if (cmd.out_load)
        begin
            res_next.numerator     = FIELD_W'(fin_p_reg);
            res_next.denominator   = FIELD_W'(fin_q_reg);
            res_next.num_class     = q_zero ? '0 : FIELD_W'(rem_p_reg);
            res_next.den_class     = p_zero ? '0 : FIELD_W'(div_rem);
            res_next.num_class_bad = q_zero;
            res_next.den_class_bad = p_zero;
            case ({fin_p_reg[0], fin_q_reg[0]})
                2'b11:   res_next.parity_code = PAR_ONE;
                2'b10:   res_next.parity_code = PAR_INFINITY;
                2'b01:   res_next.parity_code = PAR_ZERO;
                default: res_next.parity_code = PAR_FAIL;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        fin_p_reg <= fin_p_next;
        fin_q_reg <= fin_q_next;
        rem_p_reg <= rem_p_next;
        res_reg   <= res_next;
    end

    assign result = res_reg;

endmodule

[hdl/cfc_ctrl.sv]
// Controller state machine: stream handshakes and sequencing of the remainder work.
// Depends on cfc_pkg.
module cfc_ctrl
    import cfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output cfc_cmd_t cmd,
    input  cfc_sts_t sts
);

    cfc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_START_P;
                end
            end
            ST_START_P: state_next = ST_REM_P;
            ST_REM_P:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_START_Q;
                end
            end
            ST_START_Q: state_next = ST_REM_Q;
            ST_REM_Q:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd.step      = 1'b0;
        cmd.finish    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = SEL_P_MOD_Q;
        cmd.save_rem  = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                s_tready   = 1'b1;
                cmd.step   = s_tvalid;
                cmd.finish = s_tvalid && s_tlast;
            end
            ST_START_P:
            begin
                cmd.div_start = 1'b1;
            end
            ST_REM_P:
            begin
                cmd.save_rem = sts.div_done;
            end
            ST_START_Q:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_Q_MOD_P;
            end
            ST_REM_Q:
            begin
                cmd.div_sel = SEL_Q_MOD_P;
            end
            ST_EMIT:
            begin
                cmd.div_sel  = SEL_Q_MOD_P;
                cmd.out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[hdl/continued_fraction_tangle_classifier.sv]
// A word without tlast advances the recurrence; after a word with tlast the result word
// appears once the shared bit-serial remainder unit has made its two passes. Inside a
// vector one word is taken per cycle; after each last word the slave side stays closed
// until the result word is loaded. Reset (rst_n low, asynchronous) empties the output and
// returns the recurrence to p = 1, p_prev = 0, q = 0, q_prev = 1.
//
// Top level of the continued-fraction tangle classifier.
// Depends on cfc_pkg, cfc_ctrl and cfc_datapath.
//
// Each slave word carries one twist vector entry a. The datapath keeps the two most
// recent convergents and forms p' = a*p + p_prev and q' = a*q + q_prev, both wrapping
// at VALUE_WIDTH bits. On the word marked with s_tlast the final p and q are latched,
// the recurrence restarts, and the controller runs the shared remainder unit twice,
// first for p mod q and then for q mod p. The result word then goes to the output
// register, where it waits for m_tready; new entries of the next vector are taken as
// soon as the controller is back in its run state, even while that word still waits.
// A remainder by zero is reported as zero, with its flag set in m_tuser.
module continued_fraction_tangle_classifier
    import cfc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] twist
    input  logic                 s_tlast,  // last entry of the twist vector
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] numerator, [31:16] denominator, [47:32] numerator_class,
    // [63:48] denominator_class, [65:64] parity_code, [71:66] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] numerator_class_bad, [1] denominator_class_bad
    output logic [M_TUSER_W-1:0] m_tuser
);

    cfc_cmd_t    cmd;
    cfc_sts_t    sts;
    cfc_result_t result;

    cfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cfc_datapath #(
        .W (VALUE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .twist  (s_tdata[TWIST_W-1:0]),
        .result (result)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_tdata = {
        {M_PAD_W{1'b0}},
        result.parity_code,
        result.den_class,
        result.num_class,
        result.denominator,
        result.numerator
    };
    assign m_tuser = {result.den_class_bad, result.num_class_bad};

endmodule

[hdl/cfc_checker.sv]
// Port-level checker for the continued-fraction tangle classifier, with its bind.
// Depends on cfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfc_checker
    import cfc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    logic out_stall;
    logic last_in;
    logic parity_ok;
    logic zero_den_ok;

    assign out_stall   = m_tvalid && !m_tready;
    assign last_in     = s_tvalid && s_tready && s_tlast;
    assign parity_ok   = (m_tdata[65] == !m_tdata[16])
                         && (m_tdata[64] == (m_tdata[0] == m_tdata[16]));
    assign zero_den_ok = (m_tdata[31:16] == '0) && (m_tdata[47:32] == '0);

    // A stalled result word stays offered.
    `AST_NEXT(a_out_hold, out_stall, m_tvalid, "result word dropped while stalled")
    // A stalled result word keeps its contents.
    `AST_NEXT(a_out_stable, out_stall, $stable({m_tdata, m_tuser}), "stalled word changed")
    // The last word of a vector starts the remainder work, so the slave side closes.
    `AST_NEXT(a_busy_after_last, last_in, !s_tready, "slave side open after a last word")
    // The parity class follows the low bits of numerator and denominator.
    `AST_SAME(a_parity, m_tvalid, parity_ok, "parity code disagrees with fraction")
    // A flagged numerator class comes with a zero denominator and a zero class.
    `AST_SAME(a_zero_den, m_tvalid && m_tuser[0], zero_den_ok, "zero-divisor flag, nonzero fields")

endmodule

bind continued_fraction_tangle_classifier cfc_checker u_cfc_checker (.*);
